@@ rtl/core/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg: shared definitions for the cycling speed and cadence statistics
// Field widths, register map, action codes, sequencer states, the request and
// response bundles of the shared divider, and the averaging function.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int CircW   = 10;
  localparam int ThrW    = 14;
  localparam int ShiftW  = 3;
  localparam int RevW    = 32;
  localparam int CrankW  = 16;
  localparam int TickW   = 16;
  localparam int AltW    = 25;
  localparam int TempW   = 16;
  localparam int StatW   = 16;
  localparam int DistW   = 40;
  localparam int ClimbW  = 32;
  localparam int ProdW   = RevW + CircW;

  // Shared divider: numerator, denominator, quotient and iteration counter.
  localparam int DivNumW = 58;
  localparam int DivDenW = 20;
  localparam int DivQW   = 16;
  localparam int DivCntW = 5;

  // Configuration port.
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [1:0] RegCirc  = 2'd0;
  localparam logic [1:0] RegThr   = 2'd1;
  localparam logic [1:0] RegShift = 2'd2;

  localparam logic [CircW-1:0]  CircReset  = CircW'(28);
  localparam logic [ThrW-1:0]   ThrReset   = ThrW'(200);
  localparam logic [ShiftW-1:0] ShiftReset = ShiftW'(1);

  localparam logic [1:0] ActCrank = 2'd0;
  localparam logic [1:0] ActWheel = 2'd1;
  localparam logic [1:0] ActBaro  = 2'd2;

  typedef struct packed {
    logic [CircW-1:0]  circ;
    logic [ThrW-1:0]   thr;
    logic [ShiftW-1:0] shift;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivQW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRANK,
    S_WHEEL,
    S_WHEEL_DIV,
    S_DIV_WAIT,
    S_AVG,
    S_BARO,
    S_CLIMB,
    S_DONE
  } state_e;

  // avg * (2^sh - 1) + fresh, divided by 2^sh. The sum never exceeds 24 bits.
  function automatic logic [StatW-1:0] ema_update(input logic [StatW-1:0]  avg,
                                                  input logic [StatW-1:0]  fresh,
                                                  input logic [ShiftW-1:0] sh);
    logic [StatW+7:0] scaled;
    logic [StatW+7:0] sum;
    scaled = {8'b0, avg} << sh;
    sum    = scaled - {8'b0, avg} + {8'b0, fresh};
    ema_update = StatW'(sum >> sh);
  endfunction

endpackage

@@ rtl/core/csc_apb_regs.sv @@
// ----------------------------------------------------------------------------
// csc_apb_regs: configuration registers
// Holds wheel circumference, climb threshold and averaging shift behind an
// APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module csc_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csc_pkg::AddrW-1:0]  paddr,
  input  logic [csc_pkg::DataW-1:0]  pwdata,
  output logic [csc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output csc_pkg::cfg_t              cfg_o
);
  import csc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegCirc:  cfg_d.circ  = pwdata[CircW-1:0];
        RegThr:   cfg_d.thr   = pwdata[ThrW-1:0];
        RegShift: cfg_d.shift = pwdata[ShiftW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.circ  <= CircReset;
      cfg_q.thr   <= ThrReset;
      cfg_q.shift <= ShiftReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegCirc:  prdata = DataW'(cfg_q.circ);
      RegThr:   prdata = DataW'(cfg_q.thr);
      RegShift: prdata = DataW'(cfg_q.shift);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/csc_divider.sv @@
// ----------------------------------------------------------------------------
// csc_divider: shared iterative divider
// Restoring division giving a 16-bit quotient, one bit per cycle. A quotient
// that would not fit is detected at start and returned as all ones.
// ----------------------------------------------------------------------------
module csc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csc_pkg::div_req_t req_i,
  output csc_pkg::div_rsp_t rsp_o
);
  import csc_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic               sat_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivQW-1:0]   quo_q;

  logic               over;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               fits;

  // The quotient fits in 16 bits exactly when the numerator's upper part is
  // below the denominator.
  assign over  = req_i.num[DivNumW-1:DivQW] >= (DivNumW-DivQW)'(req_i.den);
  assign trial = {rem_q, quo_q[DivQW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        sat_q <= over;
        if (over) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= DivCntW'(DivQW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= req_i.num[DivQW+DivDenW-1:DivQW];
      quo_q <= req_i.num[DivQW-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivQW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sat_q ? '1 : quo_q;

endmodule

@@ rtl/core/cycling_speed_cadence_stats_unit.sv @@
// ----------------------------------------------------------------------------
// cycling_speed_cadence_stats_unit: ride statistics from sensor events
// Turns crank, wheel and barometer events into speed, cadence, their running
// averages, ride distance, filtered climb and the latest temperature.
//
//   Channel  Direction  Handshake                Contents
//   in       to block   in_valid_i / in_stall_o   one event word
//   out      from block out_valid_o / out_stall_i one statistics word
//   config   to block   APB psel/penable/pready   three registers
//
// A wheel event runs S_WHEEL and S_WHEEL_DIV, a crank event S_CRANK, then
// S_DIV_WAIT, S_AVG and S_DONE: the shared divider gives one quotient bit per
// cycle; a saturating quotient skips that loop. Barometer events add S_CLIMB
// unless first or falling; first events, zero time deltas and unknown actions
// skip to S_DONE. Reset clears all statistics and restores the defaults.
// A stalled result waits in the output register; the next event may already
// be accepted and runs until its own result is ready to be loaded.
// ----------------------------------------------------------------------------
module cycling_speed_cadence_stats_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Event channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [csc_pkg::RevW-1:0]          rev_count_i,
  input  logic [csc_pkg::TickW-1:0]         event_ticks_i,
  input  logic signed [csc_pkg::AltW-1:0]   altitude_cm_i,
  input  logic [csc_pkg::TempW-1:0]         temperature_raw_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [csc_pkg::StatW-1:0]         speed_now_o,
  output logic [csc_pkg::StatW-1:0]         speed_average_o,
  output logic [csc_pkg::StatW-1:0]         cadence_now_o,
  output logic [csc_pkg::StatW-1:0]         cadence_average_o,
  output logic [csc_pkg::DistW-1:0]         ride_distance_cm_o,
  output logic [csc_pkg::ClimbW-1:0]        ride_climb_cm_o,
  output logic [csc_pkg::TempW-1:0]         temperature_now_o,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csc_pkg::AddrW-1:0]         paddr,
  input  logic [csc_pkg::DataW-1:0]         pwdata,
  output logic [csc_pkg::DataW-1:0]         prdata,
  output logic                              pready
);
  import csc_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;

  // Latched event word.
  logic [1:0]       act_q;
  logic [RevW-1:0]  revs_q;
  logic [TickW-1:0] ticks_q;
  logic [AltW-1:0]  alt_q;
  logic [TempW-1:0] temp_q;

  // Working values.
  logic [ProdW-1:0] num_q;
  logic [TickW-1:0] dt_q;
  logic [AltW-1:0]  delta_q;

  // Statistics state.
  logic [RevW-1:0]   last_wheel_revs_q;
  logic [TickW-1:0]  last_wheel_ticks_q;
  logic              wheel_seen_q;
  logic [CrankW-1:0] last_crank_revs_q;
  logic [TickW-1:0]  last_crank_ticks_q;
  logic              crank_seen_q;
  logic [StatW-1:0]  speed_q;
  logic [StatW-1:0]  speed_avg_q;
  logic [StatW-1:0]  cadence_q;
  logic [StatW-1:0]  cadence_avg_q;
  logic [DistW-1:0]  dist_q;
  logic [AltW-1:0]   last_alt_q;
  logic              alt_seen_q;
  logic [ClimbW-1:0] run_q;
  logic [ClimbW-1:0] climb_q;
  logic [TempW-1:0]  temp_reg_q;

  // Output register.
  logic              out_valid_q;
  logic [StatW-1:0]  o_speed_q;
  logic [StatW-1:0]  o_speed_avg_q;
  logic [StatW-1:0]  o_cadence_q;
  logic [StatW-1:0]  o_cadence_avg_q;
  logic [DistW-1:0]  o_dist_q;
  logic [ClimbW-1:0] o_climb_q;
  logic [TempW-1:0]  o_temp_q;

  // Sequencer strobes.
  logic in_accept;
  logic div_start;
  logic out_load;

  // Combinational helpers.
  logic [TickW-1:0]   dt_wheel;
  logic [TickW-1:0]   dt_crank;
  logic [RevW-1:0]    dr_wheel;
  logic [CrankW-1:0]  dr_crank;
  logic [ProdW-1:0]   prod_wheel;
  logic [CrankW+3:0]  dr_crank15;
  logic [ProdW+3:0]   num_wheel9;
  logic [DivDenW-1:0] den_wheel;
  logic [DistW+2:0]   dist_sum;
  logic [AltW:0]      alt_delta;
  logic [ClimbW:0]    run_sum;
  logic [ClimbW:0]    climb_sum;
  logic               crank_go;
  logic               wheel_go;
  logic               out_free;

  csc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign dt_wheel   = ticks_q - last_wheel_ticks_q;
  assign dt_crank   = ticks_q - last_crank_ticks_q;
  assign dr_wheel   = revs_q - last_wheel_revs_q;
  assign dr_crank   = revs_q[CrankW-1:0] - last_crank_revs_q;
  assign prod_wheel = {{CircW{1'b0}}, dr_wheel} * {{RevW{1'b0}}, cfg.circ};
  assign crank_go   = crank_seen_q && (dt_crank != '0);
  assign wheel_go   = wheel_seen_q && (dt_wheel != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Speed is revs*circ*36864/(10*dt), with 36864 = 9 * 4096.
  // Cadence is revs*61440/dt, with 61440 = 15 * 4096.
  assign dr_crank15 = ({4'b0, dr_crank} << 4) - {4'b0, dr_crank};
  assign num_wheel9 = ({4'b0, num_q} << 3) + {4'b0, num_q};
  assign den_wheel  = ({4'b0, dt_q} << 3) + ({4'b0, dt_q} << 1);

  assign dist_sum  = {3'b0, dist_q} + {1'b0, num_q};
  assign alt_delta = {alt_q[AltW-1], alt_q} - {last_alt_q[AltW-1], last_alt_q};
  assign run_sum   = {1'b0, run_q} + (ClimbW+1)'(delta_q);
  assign climb_sum = {1'b0, climb_q} + (ClimbW+1)'(delta_q);

  always_comb begin
    div_req.start = div_start;
    if (state_q == S_WHEEL_DIV) begin
      div_req.num = {num_wheel9, 12'b0};
      div_req.den = den_wheel;
    end else begin
      div_req.num = DivNumW'({dr_crank15, 12'b0});
      div_req.den = DivDenW'(dt_crank);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            ActCrank: state_d = S_CRANK;
            ActWheel: state_d = S_WHEEL;
            ActBaro:  state_d = S_BARO;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_CRANK:     state_d = crank_go ? S_DIV_WAIT : S_DONE;
      S_WHEEL:     state_d = wheel_go ? S_WHEEL_DIV : S_DONE;
      S_WHEEL_DIV: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_AVG;
        end
      end
      S_AVG:       state_d = S_DONE;
      S_BARO:      state_d = (alt_seen_q && !alt_delta[AltW]) ? S_CLIMB : S_DONE;
      S_CLIMB:     state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:      in_stall_o = 1'b0;
      S_CRANK:     div_start  = crank_go;
      S_WHEEL_DIV: div_start  = 1'b1;
      S_DONE:      out_load   = out_free;
      default:     in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q   <= action_i;
      revs_q  <= rev_count_i;
      ticks_q <= event_ticks_i;
      alt_q   <= altitude_cm_i;
      temp_q  <= temperature_raw_i;
    end
    if (state_q == S_WHEEL) begin
      num_q <= prod_wheel;
      dt_q  <= dt_wheel;
    end
    if (state_q == S_BARO) begin
      delta_q <= alt_delta[AltW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_wheel_revs_q  <= '0;
      last_wheel_ticks_q <= '0;
      wheel_seen_q       <= 1'b0;
      last_crank_revs_q  <= '0;
      last_crank_ticks_q <= '0;
      crank_seen_q       <= 1'b0;
      speed_q            <= '0;
      speed_avg_q        <= '0;
      cadence_q          <= '0;
      cadence_avg_q      <= '0;
      dist_q             <= '0;
      last_alt_q         <= '0;
      alt_seen_q         <= 1'b0;
      run_q              <= '0;
      climb_q            <= '0;
      temp_reg_q         <= '0;
    end else begin
      case (state_q)
        S_CRANK: begin
          // The first crank event only seeds; a zero time delta is dropped.
          if (!crank_seen_q || crank_go) begin
            crank_seen_q       <= 1'b1;
            last_crank_revs_q  <= revs_q[CrankW-1:0];
            last_crank_ticks_q <= ticks_q;
          end
        end
        S_WHEEL: begin
          if (!wheel_seen_q || wheel_go) begin
            wheel_seen_q       <= 1'b1;
            last_wheel_revs_q  <= revs_q;
            last_wheel_ticks_q <= ticks_q;
          end
        end
        S_WHEEL_DIV: begin
          dist_q <= (dist_sum[DistW+2:DistW] != '0) ? '1 : dist_sum[DistW-1:0];
        end
        S_AVG: begin
          if (act_q == ActWheel) begin
            speed_q     <= div_rsp.quo;
            speed_avg_q <= ema_update(speed_avg_q, div_rsp.quo, cfg.shift);
          end else begin
            cadence_q     <= div_rsp.quo;
            cadence_avg_q <= ema_update(cadence_avg_q, div_rsp.quo, cfg.shift);
          end
        end
        S_BARO: begin
          temp_reg_q <= temp_q;
          last_alt_q <= alt_q;
          alt_seen_q <= 1'b1;
          // A descent restarts the climb run.
          if (alt_seen_q && alt_delta[AltW]) begin
            run_q <= '0;
          end
        end
        S_CLIMB: begin
          // The run is updated here, and the comparison below is made on the updated
          // sum rather than on run_q, so it uses the new run.
          run_q <= run_sum[ClimbW] ? '1 : run_sum[ClimbW-1:0];
        end
        default: begin
        end
      endcase
      // Gain counts once the updated run exceeds the threshold.
      if (state_q == S_CLIMB) begin
        if ((run_sum[ClimbW] ? {ClimbW{1'b1}} : run_sum[ClimbW-1:0])
            > ClimbW'(cfg.thr)) begin
          climb_q <= climb_sum[ClimbW] ? '1 : climb_sum[ClimbW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_speed_q       <= speed_q;
      o_speed_avg_q   <= speed_avg_q;
      o_cadence_q     <= cadence_q;
      o_cadence_avg_q <= cadence_avg_q;
      o_dist_q        <= dist_q;
      o_climb_q       <= climb_q;
      o_temp_q        <= temp_reg_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign speed_now_o        = o_speed_q;
  assign speed_average_o    = o_speed_avg_q;
  assign cadence_now_o      = o_cadence_q;
  assign cadence_average_o  = o_cadence_avg_q;
  assign ride_distance_cm_o = o_dist_q;
  assign ride_climb_cm_o    = o_climb_q;
  assign temperature_now_o  = o_temp_q;

endmodule

@@ dv/tb_cycling_speed_cadence_stats_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cycling_speed_cadence_stats_unit: self-checking bench for the ride stats
// Every accepted event word is run through a behavioral copy of the speed,
// cadence, distance, climb and temperature bookkeeping, and the statistics
// word it must produce is queued. Each result word from the block is compared
// field by field with the oldest queued word. Register settings are swept over
// the APB port between phases, and both channels see random idle bursts, a
// long result hold-off and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_cycling_speed_cadence_stats_unit;
  import csc_pkg::*;

  localparam logic [1:0]  ActIgnore    = 2'd3;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned HoldCycles   = 300;

  typedef struct packed {
    logic [1:0]       action;
    logic [RevW-1:0]  revs;
    logic [TickW-1:0] ticks;
    logic [AltW-1:0]  alt;
    logic [TempW-1:0] temp;
  } ride_event_t;

  typedef struct packed {
    logic [StatW-1:0]  speed;
    logic [StatW-1:0]  speed_avg;
    logic [StatW-1:0]  cadence;
    logic [StatW-1:0]  cadence_avg;
    logic [DistW-1:0]  distance;
    logic [ClimbW-1:0] climb;
    logic [TempW-1:0]  temp;
  } ride_stats_t;

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             action_i          = '0;
  logic [RevW-1:0]        rev_count_i       = '0;
  logic [TickW-1:0]       event_ticks_i     = '0;
  logic signed [AltW-1:0] altitude_cm_i     = '0;
  logic [TempW-1:0]       temperature_raw_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i       = 1'b0;
  logic [StatW-1:0]       speed_now_o;
  logic [StatW-1:0]       speed_average_o;
  logic [StatW-1:0]       cadence_now_o;
  logic [StatW-1:0]       cadence_average_o;
  logic [DistW-1:0]       ride_distance_cm_o;
  logic [ClimbW-1:0]      ride_climb_cm_o;
  logic [TempW-1:0]       temperature_now_o;
  logic                   psel              = 1'b0;
  logic                   penable           = 1'b0;
  logic                   pwrite            = 1'b0;
  logic [AddrW-1:0]       paddr             = '0;
  logic [DataW-1:0]       pwdata            = '0;
  logic [DataW-1:0]       prdata;
  logic                   pready;

  cycling_speed_cadence_stats_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Behavioral copy of the register file and the ride bookkeeping.
  logic [CircW-1:0]       circ_q     = CircReset;
  logic [ThrW-1:0]        thr_q      = ThrReset;
  logic [ShiftW-1:0]      shift_q    = ShiftReset;
  logic [RevW-1:0]        wh_revs    = '0;
  logic [TickW-1:0]       wh_ticks   = '0;
  logic                   wh_primed  = 1'b0;
  logic [CrankW-1:0]      cr_revs    = '0;
  logic [TickW-1:0]       cr_ticks   = '0;
  logic                   cr_primed  = 1'b0;
  logic [StatW-1:0]       speed_q    = '0;
  logic [StatW-1:0]       speed_avg_q = '0;
  logic [StatW-1:0]       cad_q      = '0;
  logic [StatW-1:0]       cad_avg_q  = '0;
  logic [DistW-1:0]       dist_q     = '0;
  logic signed [AltW-1:0] alt_q      = '0;
  logic                   alt_primed = 1'b0;
  logic [ClimbW-1:0]      run_q      = '0;
  logic [ClimbW-1:0]      gain_q     = '0;
  logic [TempW-1:0]       temp_q     = '0;

  // Last word of each kind that was sent, so random traffic stays plausible.
  logic [RevW-1:0]        sent_wh_revs  = '0;
  logic [TickW-1:0]       sent_wh_ticks = '0;
  logic [RevW-1:0]        sent_cr_revs  = '0;
  logic [TickW-1:0]       sent_cr_ticks = '0;
  logic signed [AltW-1:0] sent_alt      = '0;

  ride_stats_t stats_due[$];
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  bit          tx_gaps      = 1'b0;
  bit          rx_gaps      = 1'b0;
  int unsigned rx_hold_len  = 0;
  int unsigned rx_hold_seq  = 0;

  function automatic logic [StatW-1:0] clip_stat(logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[StatW-1:0];
  endfunction

  function automatic logic [StatW-1:0] smooth(logic [StatW-1:0] avg,
                                              logic [StatW-1:0] fresh);
    logic [63:0] sum;
    logic [63:0] quo;
    sum = {48'd0, avg} * ((64'd1 << shift_q) - 64'd1) + {48'd0, fresh};
    quo = sum >> shift_q;
    return quo[StatW-1:0];
  endfunction

  function automatic ride_stats_t ride_model_step(ride_event_t ev);
    logic [TickW-1:0]       dt;
    logic [RevW-1:0]        dr;
    logic [CrankW-1:0]      dc;
    logic [63:0]            num;
    logic [63:0]            sum;
    logic signed [AltW-1:0] alt;
    longint                 rise;
    ride_stats_t            res;
    case (ev.action)
      ActCrank: begin
        if (!cr_primed) begin
          cr_primed = 1'b1;
          cr_revs   = ev.revs[CrankW-1:0];
          cr_ticks  = ev.ticks;
        end else begin
          dt = ev.ticks - cr_ticks;
          if (dt != '0) begin
            dc        = ev.revs[CrankW-1:0] - cr_revs;
            cad_q     = clip_stat({48'd0, dc} * 64'd61440 / {48'd0, dt});
            cad_avg_q = smooth(cad_avg_q, cad_q);
            cr_revs   = ev.revs[CrankW-1:0];
            cr_ticks  = ev.ticks;
          end
        end
      end
      ActWheel: begin
        if (!wh_primed) begin
          wh_primed = 1'b1;
          wh_revs   = ev.revs;
          wh_ticks  = ev.ticks;
        end else begin
          dt = ev.ticks - wh_ticks;
          if (dt != '0) begin
            dr          = ev.revs - wh_revs;
            num         = {32'd0, dr} * {54'd0, circ_q};
            speed_q     = clip_stat(num * 64'd36864 / ({48'd0, dt} * 64'd10));
            speed_avg_q = smooth(speed_avg_q, speed_q);
            sum         = {24'd0, dist_q} + num;
            dist_q      = (sum > 64'hFF_FFFF_FFFF) ? '1 : sum[DistW-1:0];
            wh_revs     = ev.revs;
            wh_ticks    = ev.ticks;
          end
        end
      end
      ActBaro: begin
        temp_q = ev.temp;
        alt    = ev.alt;
        if (!alt_primed) begin
          alt_primed = 1'b1;
          alt_q      = alt;
        end else begin
          rise  = longint'(alt) - longint'(alt_q);
          alt_q = alt;
          if (rise < 0) begin
            run_q = '0;
          end else begin
            sum   = {32'd0, run_q} + 64'(rise);
            run_q = (sum > 64'hFFFF_FFFF) ? '1 : sum[ClimbW-1:0];
            // Gain only counts once the current climb run is past the threshold.
            if (run_q > {18'd0, thr_q}) begin
              sum    = {32'd0, gain_q} + 64'(rise);
              gain_q = (sum > 64'hFFFF_FFFF) ? '1 : sum[ClimbW-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    res.speed       = speed_q;
    res.speed_avg   = speed_avg_q;
    res.cadence     = cad_q;
    res.cadence_avg = cad_avg_q;
    res.distance    = dist_q;
    res.climb       = gain_q;
    res.temp        = temp_q;
    return res;
  endfunction

  function automatic ride_event_t ride_event(logic [1:0] act, logic [RevW-1:0] revs,
                                             logic [TickW-1:0] ticks, logic [AltW-1:0] alt,
                                             logic [TempW-1:0] temp);
    ride_event_t ev;
    ev.action = act;
    ev.revs   = revs;
    ev.ticks  = ticks;
    ev.alt    = alt;
    ev.temp   = temp;
    return ev;
  endfunction

  // Mostly well-formed sensor traffic, with zero time deltas and noise mixed in.
  function automatic ride_event_t next_random_event();
    ride_event_t ev;
    int unsigned pick;
    int          step;
    pick      = $urandom_range(0, 99);
    ev.action = 2'($urandom_range(0, 3));
    ev.revs   = $urandom();
    ev.ticks  = TickW'($urandom());
    ev.alt    = AltW'($urandom());
    ev.temp   = TempW'($urandom());
    if (pick < 30) begin
      ev.action = ActWheel;
      ev.revs   = sent_wh_revs + RevW'($urandom_range(0, 12));
      ev.ticks  = sent_wh_ticks + TickW'($urandom_range(1, 4000));
    end else if (pick < 55) begin
      ev.action = ActCrank;
      ev.revs   = {16'($urandom()), sent_cr_revs[15:0] + 16'($urandom_range(0, 4))};
      ev.ticks  = sent_cr_ticks + TickW'($urandom_range(1, 6000));
    end else if (pick < 80) begin
      step      = int'($urandom_range(0, 900)) - 400;
      ev.action = ActBaro;
      ev.alt    = sent_alt + AltW'(step);
    end else if (pick < 87) begin
      ev.action = ($urandom_range(0, 1) == 1) ? ActWheel : ActCrank;
      ev.ticks  = (ev.action == ActWheel) ? sent_wh_ticks : sent_cr_ticks;
      if (ev.action == ActWheel) ev.revs = sent_wh_revs + RevW'($urandom_range(0, 50));
    end else if (ev.action == ActWheel) begin
      // Keep wheel deltas bounded so the distance total does not pin early.
      ev.revs = sent_wh_revs + RevW'($urandom_range(0, 4000));
    end
    return ev;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  task automatic send_event(ride_event_t ev);
    action_i          <= ev.action;
    rev_count_i       <= ev.revs;
    event_ticks_i     <= ev.ticks;
    altitude_cm_i     <= ev.alt;
    temperature_raw_i <= ev.temp;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    stats_due.push_back(ride_model_step(ev));
    case (ev.action)
      ActWheel: begin
        sent_wh_revs  = ev.revs;
        sent_wh_ticks = ev.ticks;
      end
      ActCrank: begin
        sent_cr_revs  = ev.revs;
        sent_cr_ticks = ev.ticks;
      end
      ActBaro: sent_alt = ev.alt;
      default: ;
    endcase
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_event(next_random_event());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [1:0] idx, logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] register_image(logic [1:0] idx);
    case (idx)
      RegCirc:  return DataW'(circ_q);
      RegThr:   return DataW'(thr_q);
      RegShift: return DataW'(shift_q);
      default:  return '0;
    endcase
  endfunction

  task automatic check_register(logic [1:0] idx);
    logic [DataW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== register_image(idx))
      flag_mismatch($sformatf("register %0d readback", idx), 64'(rd),
                    64'(register_image(idx)));
  endtask

  task automatic set_register(logic [1:0] idx, logic [DataW-1:0] value);
    logic [DataW-1:0] rd;
    apb_access(1'b1, idx, value, rd);
    case (idx)
      RegCirc:  circ_q  = value[CircW-1:0];
      RegThr:   thr_q   = value[ThrW-1:0];
      RegShift: shift_q = value[ShiftW-1:0];
      default: ;
    endcase
    check_register(idx);
  endtask

  task automatic apply_settings(int unsigned circ, int unsigned thr, int unsigned shift);
    drain_results();
    set_register(RegCirc, DataW'(circ));
    set_register(RegThr, DataW'(thr));
    set_register(RegShift, DataW'(shift));
  endtask

  task automatic test_register_access();
    check_register(RegCirc);
    check_register(RegThr);
    check_register(RegShift);
  endtask

  // Runs on the reset settings: first events, zero deltas, wraps, saturation
  // of speed and cadence, the climb threshold and altitude extremes.
  task automatic test_directed_events();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_event(ride_event(ActIgnore, '1, '1, '1, '1));
    send_event(ride_event(ActCrank, 32'hABCD_FFF0, 16'hFFF0, '0, 16'h1234));
    send_event(ride_event(ActCrank, 32'hABCD_FFF5, 16'hFFF0, '0, 16'h0000));
    send_event(ride_event(ActCrank, 32'h1234_0003, 16'h0010, '0, 16'hFFFF));
    send_event(ride_event(ActCrank, 32'h0000_0004, 16'h000F, '0, 16'h00FF));
    send_event(ride_event(ActCrank, 32'hFFFF_0003, 16'h0010, '1, 16'hFF00));
    send_event(ride_event(ActWheel, 32'hFFFF_FFF0, 16'h8000, '0, 16'h5A5A));
    send_event(ride_event(ActWheel, 32'hFFFF_FFF8, 16'h8000, '0, 16'hA5A5));
    send_event(ride_event(ActWheel, 32'h0000_000A, 16'h8400, '0, 16'h0001));
    send_event(ride_event(ActWheel, 32'h0000_03F2, 16'h8401, '0, 16'h8000));
    send_event(ride_event(ActWheel, 32'h0000_03F2, 16'h85F5, '0, 16'h7FFF));
    send_event(ride_event(ActWheel, 32'h0000_03F5, 16'h0100, '0, 16'h0002));
    send_event(ride_event(ActBaro, '1, '1, 25'd0, 16'h0000));
    send_event(ride_event(ActBaro, '0, '0, 25'd150, 16'hFFFF));
    send_event(ride_event(ActBaro, '0, '0, 25'd250, 16'h1111));
    send_event(ride_event(ActBaro, '0, '0, 25'd250, 16'h2222));
    send_event(ride_event(ActBaro, '0, '0, 25'd249, 16'h4444));
    send_event(ride_event(ActBaro, '0, '0, 25'h0FF_FFFF, 16'h8888));
    send_event(ride_event(ActBaro, '0, '0, 25'h100_0000, 16'hCCCC));
    send_event(ride_event(ActBaro, '0, '0, 25'h1FF_FFFF, 16'h3333));
    send_event(ride_event(ActIgnore, '0, '0, '0, '0));
  endtask

  task automatic test_settings_sweep();
    apply_settings(1, 0, 0);
    send_random(30);
    apply_settings(1000, 10000, 4);
    send_random(30);
    apply_settings(1023, 16383, 7);
    send_random(30);
    apply_settings(0, 0, 5);
    send_random(30);
    apply_settings(700, 50, 3);
    send_random(30);
    apply_settings(28, 200, 2);
    send_random(30);
  endtask

  // The result side holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold_len = HoldCycles;
    rx_hold_seq++;
    send_random(24);
    drain_results();
  endtask

  task automatic test_random_traffic();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    apply_settings(320, 120, 1);
    send_random(160);
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random(40);
  endtask

  // Pins speed and the distance total, so it runs last.
  task automatic test_saturation();
    apply_settings(1023, 200, 1);
    send_event(ride_event(ActWheel, sent_wh_revs - 32'd1, sent_wh_ticks + 16'd1, '0, '0));
    send_event(ride_event(ActWheel, sent_wh_revs + 32'd3, sent_wh_ticks + 16'd700, '0, '0));
    send_event(ride_event(ActCrank, sent_cr_revs + 32'd1, sent_cr_ticks + 16'd900, '0, '0));
    send_event(ride_event(ActBaro, '0, '0, sent_alt + 25'd10, 16'hBEEF));
  endtask

  // Result side: random stall bursts, plus a long hold-off on request.
  int unsigned rx_left = 0;
  int unsigned rx_hold_seen = 0;
  logic        rx_busy = 1'b0;
  always @(posedge clk_i) begin
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen = rx_hold_seq;
      rx_left      = rx_hold_len;
      rx_busy      = 1'b1;
    end else if (rx_left == 0) begin
      rx_busy = rx_gaps && ($urandom_range(0, 1) == 1);
      rx_left = $urandom_range(1, 19);
    end
    rx_left = rx_left - 1;
    out_stall_i <= rx_busy;
  end

  always @(posedge clk_i) begin : check_results
    ride_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_due.size() == 0) begin
        flag_mismatch("result word with nothing pending", 64'(speed_now_o), 64'd0);
      end else begin
        want = stats_due.pop_front();
        if (speed_now_o !== want.speed)
          flag_mismatch("speed_now", 64'(speed_now_o), 64'(want.speed));
        if (speed_average_o !== want.speed_avg)
          flag_mismatch("speed_average", 64'(speed_average_o), 64'(want.speed_avg));
        if (cadence_now_o !== want.cadence)
          flag_mismatch("cadence_now", 64'(cadence_now_o), 64'(want.cadence));
        if (cadence_average_o !== want.cadence_avg)
          flag_mismatch("cadence_average", 64'(cadence_average_o), 64'(want.cadence_avg));
        if (ride_distance_cm_o !== want.distance)
          flag_mismatch("ride_distance_cm", 64'(ride_distance_cm_o), 64'(want.distance));
        if (ride_climb_cm_o !== want.climb)
          flag_mismatch("ride_climb_cm", 64'(ride_climb_cm_o), 64'(want.climb));
        if (temperature_now_o !== want.temp)
          flag_mismatch("temperature_now", 64'(temperature_now_o), 64'(want.temp));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_events();
    test_settings_sweep();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    test_saturation();
    drain_results();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ cycling_speed_cadence_stats_unit.f @@
rtl/core/csc_pkg.sv
rtl/core/csc_apb_regs.sv
rtl/core/csc_divider.sv
rtl/core/cycling_speed_cadence_stats_unit.sv
dv/tb_cycling_speed_cadence_stats_unit.sv
